[hdl/sdt_pkg.sv]
// ----------------------------------------------------------------------------
// seen device table package
// Sizes, codes and word types shared by the front queue, the slot engine
// and the top level.
// ----------------------------------------------------------------------------
package sdt_pkg;

   // table geometry
   localparam int DEVICE_SLOTS = 16;
   localparam int SLOT_W       = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;

   // report bound of one list command
   localparam int MAX_REPORTS = 16;
   localparam int CNT_W       = $clog2(MAX_REPORTS + 1);

   // field widths
   localparam int ADDR_W  = 48;
   localparam int RSSI_W  = 8;
   localparam int TIME_W  = 32;
   localparam int LIMIT_W = 5;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // command codes
   localparam logic CMD_OBSERVE = 1'b0;
   localparam logic CMD_LIST    = 1'b1;

   // timeout register value after reset
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(60000);

   // classified command word
   typedef struct packed {
      logic                     is_list;
      logic [ADDR_W-1:0]        addr;
      logic signed [RSSI_W-1:0] strength;
      logic [TIME_W-1:0]        now;
      logic [CNT_W-1:0]         limit;
   } cmd_type;

   // one slot of the table
   typedef struct packed {
      logic [ADDR_W-1:0]        addr;
      logic signed [RSSI_W-1:0] strength;
      logic [TIME_W-1:0]        seen;
   } slot_type;

   // one result word
   typedef struct packed {
      logic     valid;
      slot_type slot;
      logic     last;
   } rsp_type;

   // engine status toward the top level
   typedef struct packed {
      logic busy;
      logic is_list;
      logic out_push;
   } back_status_type;

endpackage

[hdl/sdt_front.sv]
// ----------------------------------------------------------------------------
// seen device table front end
// Accepts request words, decodes the command, saturates the list limit and
// holds the classified words in a short queue for the slot engine.
// ----------------------------------------------------------------------------
module sdt_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_cmd,
   input  logic [47:0]                      req_device_address,
   input  logic signed [7:0]                req_signal_strength,
   input  logic [31:0]                      req_now_ms,
   input  logic [4:0]                       req_list_limit,
   output logic                             cmd_valid,
   output sdt_pkg::cmd_type                 cmd_word,
   input  logic                             cmd_pop
);
   import sdt_pkg::*;

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   cmd_type           class_word;
   logic              push_ok;
   logic              pop_ok;

   // classify the incoming word
   always_comb begin
      class_word.is_list  = (req_cmd == CMD_LIST);
      class_word.addr     = req_device_address;
      class_word.strength = req_signal_strength;
      class_word.now      = req_now_ms;
      if (req_list_limit > LIMIT_W'(MAX_REPORTS)) begin
         class_word.limit = CNT_W'(MAX_REPORTS);
      end else begin
         class_word.limit = CNT_W'(req_list_limit);
      end
   end

   // queue handshake
   assign req_full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_word  = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push_ok && pop_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= class_word;
      end
   end

endmodule

[hdl/sdt_back.sv]
// ----------------------------------------------------------------------------
// seen device table slot engine
// Walks the slot memory one slot a cycle, a list waiting on a full result
// register: observe finds a match, a free slot or the oldest slot and writes
// it; list reports fresh slots, ages out stale ones and feeds that register.
// ----------------------------------------------------------------------------
module sdt_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [31:0]                      csr_timeout_ms,
   input  logic                             cmd_valid,
   input  sdt_pkg::cmd_type                 cmd_word,
   output logic                             cmd_pop,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic                             rsp_entry_valid,
   output logic [47:0]                      rsp_entry_address,
   output logic signed [7:0]                rsp_entry_strength,
   output logic [31:0]                      rsp_entry_last_seen,
   output logic                             rsp_last,
   output sdt_pkg::back_status_type         status
);
   import sdt_pkg::*;

   // engine states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_WRITE  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // slot memory and active bits
   slot_type                slot_mem [DEVICE_SLOTS];
   slot_type                rdata_ff;
   logic [DEVICE_SLOTS-1:0] active_ff;

   logic [1:0]              state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [TIME_W-1:0]       timeout_ff;
   logic [SLOT_W-1:0]       eval_idx_ff;
   logic [SLOT_W-1:0]       rd_addr;
   logic [SLOT_W-1:0]       next_idx;
   logic [CNT_W-1:0]        count_ff, count_in;
   slot_type                held_ff, held_in;
   logic                    held_valid_ff, held_valid_in;
   logic                    match_found_ff, match_found_in;
   logic [SLOT_W-1:0]       match_idx_ff, match_idx_in;
   logic                    free_found_ff, free_found_in;
   logic [SLOT_W-1:0]       free_idx_ff, free_idx_in;
   logic [SLOT_W-1:0]       min_idx_ff, min_idx_in;
   logic [TIME_W-1:0]       min_time_ff, min_time_in;
   logic                    age_clr;
   logic                    mem_we;
   logic [SLOT_W-1:0]       wr_idx;
   slot_type                wr_data;
   logic                    out_valid_ff;
   rsp_type                 out_word_ff, out_word_in;
   logic                    out_push;
   logic                    out_space;
   logic                    act;
   logic                    fresh;
   logic                    last_slot;
   logic [TIME_W-1:0]       age;

   // per-slot checks on the word read out
   assign act       = active_ff[eval_idx_ff];
   assign age       = cmd_ff.now - rdata_ff.seen;
   assign fresh     = (age <= timeout_ff);
   assign last_slot = (eval_idx_ff == SLOT_W'(DEVICE_SLOTS - 1));
   assign next_idx  = eval_idx_ff + 1'b1;
   assign out_space = !out_valid_ff || rsp_pop;
   assign wr_data   = '{addr: cmd_ff.addr, strength: cmd_ff.strength, seen: cmd_ff.now};

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      rd_addr        = eval_idx_ff;
      cmd_pop        = 1'b0;
      count_in       = count_ff;
      held_in        = held_ff;
      held_valid_in  = held_valid_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      min_idx_in     = min_idx_ff;
      min_time_in    = min_time_ff;
      age_clr        = 1'b0;
      mem_we         = 1'b0;
      wr_idx         = min_idx_ff;
      out_push       = 1'b0;
      out_word_in    = out_word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (cmd_valid) begin
               cmd_pop        = 1'b1;
               cmd_in         = cmd_word;
               count_in       = '0;
               held_valid_in  = 1'b0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               if (cmd_word.is_list && (cmd_word.limit == '0)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (!cmd_ff.is_list) begin
               // observe: track match, first free slot and oldest slot
               rd_addr = next_idx;
               if (act && (rdata_ff.addr == cmd_ff.addr) && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = eval_idx_ff;
               end
               if (!act && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = eval_idx_ff;
               end
               if ((eval_idx_ff == '0) || (rdata_ff.seen < min_time_ff)) begin
                  min_idx_in  = eval_idx_ff;
                  min_time_in = rdata_ff.seen;
               end
               if (last_slot) begin
                  state_in = ST_WRITE;
               end
            end else if (act && fresh) begin
               // list: report, holding one entry back to know the last one
               if (held_valid_ff && !out_space) begin
                  rd_addr = eval_idx_ff;
               end else begin
                  if (held_valid_ff) begin
                     out_push    = 1'b1;
                     out_word_in = '{valid: 1'b1, slot: held_ff, last: 1'b0};
                  end
                  held_in       = rdata_ff;
                  held_valid_in = 1'b1;
                  count_in      = count_ff + 1'b1;
                  rd_addr       = next_idx;
                  if (last_slot || ((count_ff + 1'b1) == cmd_ff.limit)) begin
                     state_in = ST_FINISH;
                  end
               end
            end else begin
               // list: skip inactive, age out stale
               age_clr = act;
               rd_addr = next_idx;
               if (last_slot) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_WRITE: begin
            mem_we = 1'b1;
            if (match_found_ff) begin
               wr_idx = match_idx_ff;
            end else if (free_found_ff) begin
               wr_idx = free_idx_ff;
            end
            state_in = ST_IDLE;
         end

         ST_FINISH: begin
            if (out_space) begin
               out_push = 1'b1;
               if (held_valid_ff) begin
                  out_word_in = '{valid: 1'b1, slot: held_ff, last: 1'b1};
               end else begin
                  out_word_in = '{valid: 1'b0, slot: '0, last: 1'b1};
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         active_ff     <= '0;
         timeout_ff    <= TIMEOUT_RESET;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         if (out_push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         if (age_clr) begin
            active_ff[eval_idx_ff] <= 1'b0;
         end
         if (mem_we) begin
            active_ff[wr_idx] <= 1'b1;
         end
         if (csr_wr_en) begin
            timeout_ff <= csr_timeout_ms;
         end
      end
   end

   // walk payload registers
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      count_ff       <= count_in;
      held_ff        <= held_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      min_idx_ff     <= min_idx_in;
      min_time_ff    <= min_time_in;
      eval_idx_ff    <= rd_addr;
      if (out_push) begin
         out_word_ff <= out_word_in;
      end
   end

   // slot memory, registered read
   always_ff @(posedge clock) begin
      rdata_ff <= slot_mem[rd_addr];
      if (mem_we) begin
         slot_mem[wr_idx] <= wr_data;
      end
   end

   // result port
   assign rsp_empty           = !out_valid_ff;
   assign rsp_entry_valid     = out_word_ff.valid;
   assign rsp_entry_address   = out_word_ff.slot.addr;
   assign rsp_entry_strength  = out_word_ff.slot.strength;
   assign rsp_entry_last_seen = out_word_ff.slot.seen;
   assign rsp_last            = out_word_ff.last;

   // status toward the top
   assign status.busy     = (state_ff != ST_IDLE);
   assign status.is_list  = cmd_ff.is_list;
   assign status.out_push = out_push;

endmodule

[hdl/seen_device_table_top.sv]
// ----------------------------------------------------------------------------
// seen device table
// Table of recently seen devices with aging: observe words update or replace
// a slot, list words report fresh slots and retire stale ones.
// ----------------------------------------------------------------------------
//
//   channel   ports                         word
//   --------  ----------------------------  ---------------------------------
//   request   req_push / req_full           cmd, address, strength, time, limit
//   response  rsp_pop / rsp_empty           valid, address, strength, seen, last
//   control   csr_wr_en / csr_timeout_ms    timeout in ms, no read-back
//
// In the slot engine an observe reads one slot from the slot memory per
// cycle, then writes the chosen slot.
// A list reads one slot per cycle while the response side does not stall;
// it stops early once the report limit is met.
// A two-word queue sits between the front end and the slot engine, so
// request words are taken while the engine works.
// Reset clears the active bits and the queues and loads the timeout register
// with TIMEOUT_RESET; no clearing pass is needed.
// ----------------------------------------------------------------------------
module seen_device_table_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_cmd,
   input  logic [47:0]        req_device_address,
   input  logic signed [7:0]  req_signal_strength,
   input  logic [31:0]        req_now_ms,
   input  logic [4:0]         req_list_limit,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_entry_valid,
   output logic [47:0]        rsp_entry_address,
   output logic signed [7:0]  rsp_entry_strength,
   output logic [31:0]        rsp_entry_last_seen,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_timeout_ms
);
   import sdt_pkg::*;

   logic            cmd_valid;
   cmd_type         cmd_word;
   logic            cmd_pop;
   back_status_type status;

   // front end: accept, classify, queue
   sdt_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_cmd             (req_cmd),
      .req_device_address  (req_device_address),
      .req_signal_strength (req_signal_strength),
      .req_now_ms          (req_now_ms),
      .req_list_limit      (req_list_limit),
      .cmd_valid           (cmd_valid),
      .cmd_word            (cmd_word),
      .cmd_pop             (cmd_pop)
   );

   // slot engine
   sdt_back u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_timeout_ms      (csr_timeout_ms),
      .cmd_valid           (cmd_valid),
      .cmd_word            (cmd_word),
      .cmd_pop             (cmd_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_entry_valid     (rsp_entry_valid),
      .rsp_entry_address   (rsp_entry_address),
      .rsp_entry_strength  (rsp_entry_strength),
      .rsp_entry_last_seen (rsp_entry_last_seen),
      .rsp_last            (rsp_last),
      .status              (status)
   );

   // response queue comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response word present after reset");

   // only a list in progress produces response words
   a_push_list: assert property (@(posedge clock) disable iff (reset)
      status.out_push |-> (status.is_list && status.busy))
      else $error("response word pushed outside a list walk");

   // an empty list marker is always the final word
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_entry_valid) |-> rsp_last)
      else $error("empty list marker without last");

   // a pop from a full command queue frees a place
   a_queue_drain: assert property (@(posedge clock) disable iff (reset)
      (req_full && cmd_pop) |=> !req_full)
      else $error("command queue still full after pop");

endmodule
